// ===== design/eucl_pkg.sv =====
// ----------------------------------------------------------------------------
// eucl_pkg
// Shared widths, types and helpers for the point distance pipeline.
// ----------------------------------------------------------------------------
package eucl_pkg;

    localparam int COORD_W       = 16;
    localparam int DIFF_W        = 16;
    localparam int SQ_W          = 2 * DIFF_W;
    localparam int SUM_W         = SQ_W + 2;
    localparam int DIST_W        = 25;
    localparam int FRACTION_BITS = 8;

    // root is formed two sum bits per step, then one extra step per fraction bit
    localparam int SUM_PAIRS  = (SUM_W + 1) / 2;
    localparam int PEND_W     = 2 * SUM_PAIRS;
    localparam int ROOT_STEPS = SUM_PAIRS + FRACTION_BITS;
    localparam int ROOT_W     = ROOT_STEPS;
    localparam int REM_W      = ROOT_W + 2;

    localparam int CMP_W = ROOT_W + DIST_W;
    localparam logic [CMP_W-1:0] DIST_MAX = CMP_W'({DIST_W{1'b1}});

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [PEND_W-1:0] pend;
    } t_root_word;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [ROOT_W-1:0] root);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(root);
        if (wide > DIST_MAX) begin
            return {DIST_W{1'b1}};
        end
        return wide[DIST_W-1:0];
    endfunction

endpackage

// ===== design/eucl_front.sv =====
// ----------------------------------------------------------------------------
// eucl_front
// Axis differences, squares and sum of squares over three registered stages.
// ----------------------------------------------------------------------------
module eucl_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic                   i_three_dim,
    input  eucl_pkg::t_coord       i_first_x,
    input  eucl_pkg::t_coord       i_first_y,
    input  eucl_pkg::t_coord       i_first_z,
    input  eucl_pkg::t_coord       i_second_x,
    input  eucl_pkg::t_coord       i_second_y,
    input  eucl_pkg::t_coord       i_second_z,
    output logic                   o_valid,
    output eucl_pkg::t_root_word   o_word
);
    import eucl_pkg::*;

    function automatic logic [DIFF_W-1:0] abs_diff(input t_coord a, input t_coord b);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[DIFF_W-1:0];
    endfunction

    logic [2:0]        r_valid;
    logic [DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic [SQ_W-1:0]   r_sx, r_sy, r_sz;
    logic [SUM_W-1:0]  r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= abs_diff(i_first_x, i_second_x);
            r_dy  <= abs_diff(i_first_y, i_second_y);
            // z drops out in plane mode
            r_dz  <= i_three_dim ? abs_diff(i_first_z, i_second_z) : '0;
            r_sx  <= r_dx * r_dx;
            r_sy  <= r_dy * r_dy;
            r_sz  <= r_dz * r_dz;
            r_sum <= SUM_W'(r_sx) + SUM_W'(r_sy) + SUM_W'(r_sz);
        end
    end

    assign o_valid     = r_valid[2];
    assign o_word.rem  = '0;
    assign o_word.root = '0;
    assign o_word.pend = PEND_W'(r_sum);

endmodule

// ===== design/eucl_root_cell.sv =====
// ----------------------------------------------------------------------------
// eucl_root_cell
// One restoring square root step; takes the next two sum bits from the top.
// ----------------------------------------------------------------------------
module eucl_root_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  eucl_pkg::t_root_word   i_word,
    output logic                   o_valid,
    output eucl_pkg::t_root_word   o_word
);
    import eucl_pkg::*;

    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             fits;
    t_root_word       n_word;
    logic             r_valid;
    t_root_word       r_word;

    always_comb begin
        rem_sh      = {i_word.rem, i_word.pend[PEND_W-1 -: 2]};
        trial       = (REM_W + 2)'({i_word.root, 2'b01});
        diff        = rem_sh - trial;
        fits        = (rem_sh >= trial);
        n_word.rem  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        n_word.root = {i_word.root[ROOT_W-2:0], fits};
        n_word.pend = {i_word.pend[PEND_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== design/euclidean_distance_2d_3d.sv =====
// ----------------------------------------------------------------------------
// euclidean_distance_2d_3d
// Distance between two points in the plane or in space, fixed-point root.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 word
//  in        input      i_in_valid / o_in_stall   two points, six coordinates
//  out       output     o_out_valid / i_out_stall distance, 8 fraction bits
//  cfg       input      i_cfg_valid / o_cfg_ready plane or space mode
//
//  one word per cycle while the output is not stalled; the pipe holds
//  3 front stages plus 25 root cells
//  a stall on a valid output freezes the whole pipe; one extra word is held
//  in an input skid register, and o_in_stall comes straight from it
//  synchronous active-low reset clears valid bits and sets space mode
// ----------------------------------------------------------------------------
module euclidean_distance_2d_3d (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  eucl_pkg::t_coord              i_first_x,
    input  eucl_pkg::t_coord              i_first_y,
    input  eucl_pkg::t_coord              i_first_z,
    input  eucl_pkg::t_coord              i_second_x,
    input  eucl_pkg::t_coord              i_second_y,
    input  eucl_pkg::t_coord              i_second_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [eucl_pkg::DIST_W-1:0]   o_distance,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data
);
    import eucl_pkg::*;

    logic       r_three_dim;
    logic       r_skid_valid;
    t_coord     r_sk_fx, r_sk_fy, r_sk_fz, r_sk_sx, r_sk_sy, r_sk_sz;
    logic       w_adv;
    logic       w_accept;
    logic       w_feed_valid;
    t_coord     w_fx, w_fy, w_fz, w_sx, w_sy, w_sz;

    logic       w_valid [ROOT_STEPS+1];
    t_root_word w_word  [ROOT_STEPS+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three_dim <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_three_dim <= i_cfg_data;
        end
    end

    // last cell is the output register
    assign w_adv    = !o_out_valid || !i_out_stall;
    assign w_accept = i_in_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (w_adv) begin
            r_skid_valid <= 1'b0;
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_adv && w_accept) begin
            r_sk_fx <= i_first_x;
            r_sk_fy <= i_first_y;
            r_sk_fz <= i_first_z;
            r_sk_sx <= i_second_x;
            r_sk_sy <= i_second_y;
            r_sk_sz <= i_second_z;
        end
    end

    assign o_in_stall   = r_skid_valid;
    assign w_feed_valid = r_skid_valid || w_accept;
    assign w_fx = r_skid_valid ? r_sk_fx : i_first_x;
    assign w_fy = r_skid_valid ? r_sk_fy : i_first_y;
    assign w_fz = r_skid_valid ? r_sk_fz : i_first_z;
    assign w_sx = r_skid_valid ? r_sk_sx : i_second_x;
    assign w_sy = r_skid_valid ? r_sk_sy : i_second_y;
    assign w_sz = r_skid_valid ? r_sk_sz : i_second_z;

    eucl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv),
        .i_valid     (w_feed_valid),
        .i_three_dim (r_three_dim),
        .i_first_x   (w_fx),
        .i_first_y   (w_fy),
        .i_first_z   (w_fz),
        .i_second_x  (w_sx),
        .i_second_y  (w_sy),
        .i_second_z  (w_sz),
        .o_valid     (w_valid[0]),
        .o_word      (w_word[0])
    );

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_cell
        eucl_root_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_valid (w_valid[k]),
            .i_word  (w_word[k]),
            .o_valid (w_valid[k+1]),
            .o_word  (w_word[k+1])
        );
    end

    assign o_out_valid = w_valid[ROOT_STEPS];
    assign o_distance  = sat_dist(w_word[ROOT_STEPS].root);

`ifndef SYNTHESIS
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(!w_adv && i_in_valid))
        else $error("skid filled while pipe was moving");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && w_adv |=> !r_skid_valid)
        else $error("skid word not drained on advance");

    a_hold_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_valid[ROOT_STEPS - 1]))
        else $error("pipe moved while output held");
`endif

endmodule

// ===== bench/tb_euclidean_distance_2d_3d.sv =====
// ----------------------------------------------------------------------------
// tb_euclidean_distance_2d_3d
// Self-checking bench for the point distance pipeline. A short table of
// directed point pairs covers extreme coordinates and both modes, with some
// distances typed in. Random pairs follow in phases of sender idling and
// receiver stalling. Every distance is checked in order against a typed-in
// value or a local integer square root model.
// ----------------------------------------------------------------------------
module tb_euclidean_distance_2d_3d;

    timeunit 1ns;
    timeprecision 1ps;

    import eucl_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PHASE_ITEMS = 160;
    localparam int N_DIRECTED  = 20;

    localparam logic MODE_PLANE = 1'b0;
    localparam logic MODE_SPACE = 1'b1;

    typedef struct packed {
        t_coord fx;
        t_coord fy;
        t_coord fz;
        t_coord sx;
        t_coord sy;
        t_coord sz;
    } t_point_pair;

    typedef struct packed {
        logic              mode;
        t_point_pair       pts;
        logic              known;
        logic [DIST_W-1:0] exp_dist;
    } t_dir_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_coord            i_first_x   = '0;
    t_coord            i_first_y   = '0;
    t_coord            i_first_z   = '0;
    t_coord            i_second_x  = '0;
    t_coord            i_second_y  = '0;
    t_coord            i_second_z  = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [DIST_W-1:0] o_distance;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_data  = 1'b0;

    logic [DIST_W-1:0] pending_dist[$];
    logic              space_mode     = MODE_SPACE;
    int                send_idle_pct  = 0;
    int                stall_pct      = 0;
    int                err_count      = 0;
    int                pairs_sent     = 0;
    int                dist_checked   = 0;
    int                mode_writes    = 0;
    int                cycle_count    = 0;

    // directed pairs: mode, first x y z, second x y z, typed-in flag, distance
    t_dir_row dir_rows [N_DIRECTED] = '{
        '{MODE_SPACE, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 25'd0},
        '{MODE_SPACE, '{-16'sd32768, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0},
          1'b1, 25'd16776960},
        '{MODE_SPACE, '{16'sd32767, -16'sd32768, 16'sd32767,
                        -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, 25'd0},
        '{MODE_SPACE, '{16'sd1, 16'sd2, 16'sd2, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 25'd768},
        '{MODE_SPACE, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1}, 1'b1, 25'd256},
        '{MODE_SPACE, '{-16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 25'd0},
        '{MODE_SPACE, '{16'sd32767, 16'sd32767, 16'sd32767,
                        16'sd32767, 16'sd32767, 16'sd32767}, 1'b1, 25'd0},
        '{MODE_SPACE, '{-16'sd32768, -16'sd32768, -16'sd32768,
                        -16'sd32768, -16'sd32768, -16'sd32768}, 1'b1, 25'd0},
        '{MODE_SPACE, '{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767},
          1'b1, 25'd16776960},
        '{MODE_SPACE, '{16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 25'd0},
        '{MODE_SPACE, '{16'sd12345, -16'sd2222, 16'sd777,
                        -16'sd5000, 16'sd3000, -16'sd9}, 1'b0, 25'd0},
        // plane mode: z must drop out even at its extremes
        '{MODE_PLANE, '{16'sd3, 16'sd4, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767},
          1'b1, 25'd1280},
        '{MODE_PLANE, '{-16'sd32768, -16'sd32768, 16'sd0,
                        16'sd32767, 16'sd32767, 16'sd0}, 1'b0, 25'd0},
        '{MODE_PLANE, '{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, -16'sd32768},
          1'b1, 25'd0},
        '{MODE_PLANE, '{16'sd0, -16'sd32768, 16'sd5, 16'sd0, 16'sd32767, -16'sd5},
          1'b1, 25'd16776960},
        '{MODE_PLANE, '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 25'd256},
        '{MODE_PLANE, '{-16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, 16'sd0}, 1'b0, 25'd0},
        '{MODE_PLANE, '{16'sd21, -16'sd7, 16'sd100, 16'sd0, 16'sd13, -16'sd100},
          1'b1, 25'd7424},
        '{MODE_SPACE, '{16'sd2, 16'sd3, 16'sd6, 16'sd0, 16'sd0, 16'sd0}, 1'b1, 25'd1792},
        '{MODE_SPACE, '{-16'sd32768, 16'sd32767, 16'sd0,
                        16'sd32767, -16'sd32768, 16'sd0}, 1'b0, 25'd0}
    };

    euclidean_distance_2d_3d i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_first_x  (i_first_x),
        .i_first_y  (i_first_y),
        .i_first_z  (i_first_z),
        .i_second_x (i_second_x),
        .i_second_y (i_second_y),
        .i_second_z (i_second_z),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_distance (o_distance),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // floor(sqrt(sum of squares) * 2^FRACTION_BITS), bit by bit from the top
    function automatic logic [DIST_W-1:0] point_distance(input t_point_pair p,
                                                          input logic space);
        longint d;
        longint unsigned sum;
        longint unsigned scaled;
        longint unsigned root;
        longint unsigned cand;
        d = longint'(p.fx) - longint'(p.sx);
        sum = (d < 0) ? longint'(-d * -d) : longint'(d * d);
        d = longint'(p.fy) - longint'(p.sy);
        sum += d * d;
        if (space) begin
            d = longint'(p.fz) - longint'(p.sz);
            sum += d * d;
        end
        scaled = sum << (2 * FRACTION_BITS);
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= scaled) begin
                root = cand;
            end
        end
        if (root > ((64'd1 << DIST_W) - 1)) begin
            root = (64'd1 << DIST_W) - 1;
        end
        return root[DIST_W-1:0];
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
            1: return t_coord'($urandom_range(0, 255)) - 16'sd128;
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_point_pair rand_pair();
        t_point_pair p;
        p.fx = rand_coord();
        p.fy = rand_coord();
        p.fz = rand_coord();
        case ($urandom_range(3))
            // second point close to the first, wrapping is fine
            0: begin
                p.sx = p.fx + t_coord'($urandom_range(0, 32)) - 16'sd16;
                p.sy = p.fy + t_coord'($urandom_range(0, 32)) - 16'sd16;
                p.sz = p.fz + t_coord'($urandom_range(0, 32)) - 16'sd16;
            end
            1: begin
                p.sx = p.fx;
                p.sy = p.fy;
                p.sz = rand_coord();
            end
            default: begin
                p.sx = rand_coord();
                p.sy = rand_coord();
                p.sz = rand_coord();
            end
        endcase
        return p;
    endfunction

    task automatic send_pair(input t_point_pair p, input logic known,
                             input logic [DIST_W-1:0] exp_dist);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first_x  <= p.fx;
        i_first_y  <= p.fy;
        i_first_z  <= p.fz;
        i_second_x <= p.sx;
        i_second_y <= p.sy;
        i_second_z <= p.sz;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        pending_dist.push_back(known ? exp_dist : point_distance(p, space_mode));
        pairs_sent++;
    endtask

    // called right after the last accepted word, in that same time step
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_dist.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_mode(input logic m);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        space_mode = m;
        mode_writes++;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_out
        logic [DIST_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_dist.size() == 0) begin
                $display("%0t: distance %0d with no word pending", $time, o_distance);
                err_count++;
            end else begin
                want = pending_dist.pop_front();
                dist_checked++;
                if (o_distance !== want) begin
                    $display("%0t: distance expected %0d actual %0d",
                             $time, want, o_distance);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d distances pending",
                     cycle_count, pending_dist.size());
            $display("euclidean_distance_2d_3d: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, first rows rely on space mode out of reset
        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != space_mode) begin
                drain_results();
                write_mode(dir_rows[i].mode);
            end
            send_pair(dir_rows[i].pts, dir_rows[i].known, dir_rows[i].exp_dist);
        end
        drain_results();

        // idling phases: none, sender, receiver, both; two modes per phase
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 84 : (ph == 3) ? 21 : 0;
            stall_pct     = (ph == 2) ? 84 : (ph == 3) ? 21 : 0;
            for (int half = 0; half < 2; half++) begin
                write_mode(logic'(half[0] ^ ph[0]));
                repeat (PHASE_ITEMS) begin
                    send_pair(rand_pair(), 1'b0, '0);
                end
                drain_results();
            end
        end

        stall_pct = 0;
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_dist.size() != 0) begin
            $display("%0t: %0d distances never arrived", $time, pending_dist.size());
            err_count++;
        end

        $display("%0d point pairs (%0d from the table) in plane and space mode,",
                 pairs_sent, N_DIRECTED);
        $display("%0d mode writes, %0d distances checked, %0d errors",
                 mode_writes, dist_checked, err_count);
        if (err_count == 0) begin
            $display("euclidean_distance_2d_3d: match");
        end else begin
            $display("euclidean_distance_2d_3d: mismatch");
        end
        $finish;
    end

endmodule
